### hw/rtl/ldtv_pkg.sv
`default_nettype none

package ldtv_pkg;

    // Width of the coefficient and right-hand-side fields
    localparam int DATA_WIDTH = 32;
    // Width of the particular solution
    localparam int PROD_W     = 64;
    // Bezout coefficients stay within +-2^(DATA_WIDTH) or so; a few guard bits
    localparam int COEF_W     = DATA_WIDTH + 4;
    // Counts the quotient bits of one division pass
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_a;
        logic signed [DATA_WIDTH-1:0] coef_b;
        logic signed [DATA_WIDTH-1:0] rhs;
    } ldtv_in_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]     x_out;
        logic signed [PROD_W-1:0]     y_out;
        logic signed [DATA_WIDTH-1:0] gcd_out;
        logic                         solvable;
    } ldtv_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FDIV,
        ST_FIN
    } ldtv_state_t;

    // Magnitude of a two's complement field; the most negative value maps to 2^(W-1)
    function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] u;
        u = v;
        return u[DATA_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/linear_diophantine_two_var.sv
`default_nettype none

// Solves a*x + b*y = c for one item (coef_a, coef_b, rhs) by the extended
// Euclidean algorithm with truncating division, and returns one result item:
// gcd_out is g as the truncating remainders leave it (it may be negative),
// x_out/y_out are the Bezout coefficients scaled by c/g (64-bit, never wrap),
// and solvable says whether g divides c; when it does not, x_out and y_out
// are zero. With a = b = 0 the item is solvable only for c = 0, with zeros.
// Every Euclid step runs one pass of a shared bit-serial restoring divider,
// one quotient bit per cycle; a step runs through the check, divide and
// update states. The final division of c by g uses the same divider.
// The block takes one item at a time (req_ready only while idle);
// a finished result sits in an output register so the next item can be
// accepted while it waits to be taken.
module linear_diophantine_two_var (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      req_valid,
    output logic                     req_ready,
    input  wire ldtv_pkg::ldtv_in_t  req_item,
    output logic                     rsp_valid,
    input  wire                      rsp_ready,
    output ldtv_pkg::ldtv_out_t      rsp_item
);
    import ldtv_pkg::*;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    ldtv_state_t state_reg, state_next;

    // Euclid remainder pair (old, new); starts as (b, a)
    logic signed [DATA_WIDTH-1:0] r_old_reg, r_old_next;
    logic signed [DATA_WIDTH-1:0] r_new_reg, r_new_next;
    // Coefficients of a and of b that go with each remainder
    logic signed [COEF_W-1:0]     ca_old_reg, ca_old_next;
    logic signed [COEF_W-1:0]     ca_new_reg, ca_new_next;
    logic signed [COEF_W-1:0]     cb_old_reg, cb_old_next;
    logic signed [COEF_W-1:0]     cb_new_reg, cb_new_next;
    logic signed [DATA_WIDTH-1:0] c_reg, c_next;

    // Shared divider: partial remainder, dividend/quotient shifter, divisor
    logic [DATA_WIDTH-1:0]        rem_reg, rem_next;
    logic [DATA_WIDTH-1:0]        quo_reg, quo_next;
    logic [DATA_WIDTH-1:0]        dsr_reg, dsr_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    // Quotient sign, and dividend sign (sign of the truncating remainder)
    logic                         qneg_reg, qneg_next;
    logic                         rneg_reg, rneg_next;
    // Horner accumulators: |q| times a coefficient, built MSB first
    logic signed [PROD_W-1:0]     acc0_reg, acc0_next;
    logic signed [PROD_W-1:0]     acc1_reg, acc1_next;

    // Output register
    ldtv_out_t                    out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    // ---------------------------------------------------------------
    // Divider step datapath
    // ---------------------------------------------------------------
    logic [DATA_WIDTH:0]          shifted;
    logic [DATA_WIDTH+1:0]        diff;
    logic                         qbit;
    logic signed [PROD_W-1:0]     m0, m1;
    logic signed [PROD_W-1:0]     ca_upd, cb_upd;
    logic                         out_free;

    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign qbit    = ~diff[DATA_WIDTH+1];

    // Euclid steps multiply the "new" coefficients; the final pass
    // multiplies the Bezout coefficients by c/g.
    assign m0 = (state_reg == ST_FDIV) ? PROD_W'(ca_old_reg) : PROD_W'(ca_new_reg);
    assign m1 = (state_reg == ST_FDIV) ? PROD_W'(cb_old_reg) : PROD_W'(cb_new_reg);

    // old - q*new, with q = sign * |q|
    assign ca_upd = qneg_reg ? (PROD_W'(ca_old_reg) + acc0_reg)
                             : (PROD_W'(ca_old_reg) - acc0_reg);
    assign cb_upd = qneg_reg ? (PROD_W'(cb_old_reg) + acc1_reg)
                             : (PROD_W'(cb_old_reg) - acc1_reg);

    assign out_free = !out_valid_reg || rsp_ready;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (r_new_reg != '0)
                    state_next = ST_DIV;
                else if (r_old_reg == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_FDIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
                state_next = ST_CHECK;
            ST_FDIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs and datapath controls
    // ---------------------------------------------------------------
    always_comb
    begin
        req_ready      = 1'b0;
        r_old_next     = r_old_reg;
        r_new_next     = r_new_reg;
        ca_old_next    = ca_old_reg;
        ca_new_next    = ca_new_reg;
        cb_old_next    = cb_old_reg;
        cb_new_next    = cb_new_reg;
        c_next         = c_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        qneg_next      = qneg_reg;
        rneg_next      = rneg_reg;
        acc0_next      = acc0_reg;
        acc1_next      = acc1_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                // remainders run from (b, a); b starts with ca=0, cb=1, a with ca=1, cb=0
                r_old_next  = req_item.coef_b;
                r_new_next  = req_item.coef_a;
                cb_old_next = COEF_W'(1);
                cb_new_next = '0;
                ca_old_next = '0;
                ca_new_next = COEF_W'(1);
                c_next      = req_item.rhs;
            end
            ST_CHECK:
            begin
                rem_next  = '0;
                acc0_next = '0;
                acc1_next = '0;
                cnt_next  = CNT_W'(DATA_WIDTH - 1);
                if (r_new_reg != '0)
                begin
                    // Euclid step: r_old / r_new
                    quo_next  = mag(r_old_reg);
                    dsr_next  = mag(r_new_reg);
                    qneg_next = r_old_reg[DATA_WIDTH-1] ^ r_new_reg[DATA_WIDTH-1];
                    rneg_next = r_old_reg[DATA_WIDTH-1];
                end
                else
                begin
                    // final pass: c / g (skipped when g is zero)
                    quo_next  = mag(c_reg);
                    dsr_next  = mag(r_old_reg);
                    qneg_next = c_reg[DATA_WIDTH-1] ^ r_old_reg[DATA_WIDTH-1];
                    rneg_next = c_reg[DATA_WIDTH-1];
                end
            end
            ST_DIV, ST_FDIV:
            begin
                rem_next  = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
                quo_next  = {quo_reg[DATA_WIDTH-2:0], qbit};
                acc0_next = (acc0_reg <<< 1) + (qbit ? m0 : '0);
                acc1_next = (acc1_reg <<< 1) + (qbit ? m1 : '0);
                cnt_next  = cnt_reg - 1'b1;
            end
            ST_UPDATE:
            begin
                // truncating remainder takes the dividend's sign
                r_old_next  = r_new_reg;
                r_new_next  = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
                ca_old_next = ca_new_reg;
                ca_new_next = ca_upd[COEF_W-1:0];
                cb_old_next = cb_new_reg;
                cb_new_next = cb_upd[COEF_W-1:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.gcd_out = r_old_reg;
                    if (r_old_reg == '0)
                    begin
                        out_next.solvable = (c_reg == '0);
                        out_next.x_out    = '0;
                        out_next.y_out    = '0;
                    end
                    else if (rem_reg == '0)
                    begin
                        out_next.solvable = 1'b1;
                        out_next.x_out    = qneg_reg ? -acc0_reg : acc0_reg;
                        out_next.y_out    = qneg_reg ? -acc1_reg : acc1_reg;
                    end
                    else
                    begin
                        out_next.solvable = 1'b0;
                        out_next.x_out    = '0;
                        out_next.y_out    = '0;
                    end
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_old_reg  <= r_old_next;
        r_new_reg  <= r_new_next;
        ca_old_reg <= ca_old_next;
        ca_new_reg <= ca_new_next;
        cb_old_reg <= cb_old_next;
        cb_new_reg <= cb_new_next;
        c_reg      <= c_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dsr_reg    <= dsr_next;
        cnt_reg    <= cnt_next;
        qneg_reg   <= qneg_next;
        rneg_reg   <= rneg_next;
        acc0_reg   <= acc0_next;
        acc1_reg   <= acc1_next;
        out_reg    <= out_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // divider never runs on a zero divisor
    a_dsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) || (state_reg == ST_FDIV)) |-> (dsr_reg != '0))
        else $error("divider running with zero divisor");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) || (state_reg == ST_FDIV)) |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");

    // each Euclid step shrinks the remainder magnitude
    a_euclid_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (mag(r_new_reg) < mag(r_old_reg)))
        else $error("Euclid remainder did not shrink");

    // an accepted item always starts at the check step
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_CHECK))
        else $error("accepted item did not start the sequence");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldtv_pkg::*;

    localparam logic [DATA_WIDTH-1:0] S_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] S_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] S_NEG1 = '1;

    // Slowest correct run: ~525 items, each with up to 46 Euclid steps,
    // plus sender gaps, receiver stalls and the hold-off. Take it ~4x over.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    // Longest single item; used as the settle time before the verdict.
    localparam int unsigned ITEM_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 500;

    // Scoreboard: holds the expected solutions of accepted items, in order, and
    // checks each returned result against the oldest one.
    class solution_board;
        ldtv_out_t   pending_solutions[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        // One line per mismatch, and count it.
        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            fail_count++;
        endtask

        // Extended Euclid with truncating division, all in 64 bits.
        function ldtv_out_t solve_eq(ldtv_in_t it);
            longint    c_rhs, r_old, r_new, u_old, u_new, v_old, v_new, q, t, k;
            ldtv_out_t res;
            r_old = $signed(it.coef_b);
            r_new = $signed(it.coef_a);
            c_rhs = $signed(it.rhs);
            v_old = 1;   // coefficient of b
            v_new = 0;
            u_old = 0;   // coefficient of a
            u_new = 1;
            while (r_new != 0)
            begin
                q = r_old / r_new;
                t = r_old - q * r_new; r_old = r_new; r_new = t;
                t = v_old - q * v_new; v_old = v_new; v_new = t;
                t = u_old - q * u_new; u_old = u_new; u_new = t;
            end
            res = '0;
            res.gcd_out = r_old[DATA_WIDTH-1:0];
            if (r_old == 0)
                res.solvable = (c_rhs == 0);
            else if ((c_rhs % r_old) == 0)
            begin
                k = c_rhs / r_old;
                res.solvable = 1'b1;
                res.x_out = u_old * k;
                res.y_out = v_old * k;
            end
            return res;
        endfunction

        task note_item(ldtv_in_t it);
            pending_solutions.insert(pending_solutions.size(), solve_eq(it));
        endtask

        task check_result(ldtv_out_t got);
            ldtv_out_t want;
            if (pending_solutions.size() == 0)
            begin
                report($sformatf("result with nothing expected: x=%0d y=%0d g=%0d ok=%0b",
                                 got.x_out, got.y_out, got.gcd_out, got.solvable));
                return;
            end
            want = pending_solutions.pop_front();
            if (got.x_out !== want.x_out)
                report($sformatf("x_out %0d, expected %0d", got.x_out, want.x_out));
            if (got.y_out !== want.y_out)
                report($sformatf("y_out %0d, expected %0d", got.y_out, want.y_out));
            if (got.gcd_out !== want.gcd_out)
                report($sformatf("gcd_out %0d, expected %0d", got.gcd_out, want.gcd_out));
            if (got.solvable !== want.solvable)
                report($sformatf("solvable %0b, expected %0b", got.solvable, want.solvable));
        endtask

        function int pending();
            return pending_solutions.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    ldtv_in_t  req_item;
    logic      rsp_valid;
    logic      rsp_ready;
    ldtv_out_t rsp_item;

    solution_board board;

    // Idle percentages for the two sides; changed between stimulus phases.
    int sender_idle_pct;
    int recv_idle_pct;
    // Set by the stimulus to ask the receiver for a long hold-off.
    int hold_request;
    int unsigned cycle_count;

    linear_diophantine_two_var dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Monitors sample at the edge, so they see the values the block saw.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            board.note_item(req_item);
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp_item);
    end

    // Hard stop if the block hangs or drops items.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls per cycle, or one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    initial
    begin
        int n;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                rsp_ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item. Any idle gap comes first, so valid is never dropped
    // and raised in the same step. Returns at the edge that accepts it.
    task automatic offer(input ldtv_in_t it);
        int gap;
        gap = 0;
        if (sender_idle_pct > 0 && $urandom_range(9) == 0)
            gap = $urandom_range(1200, 1);   // long gap: lands at any point of a solve
        else
            while ($urandom_range(99) < sender_idle_pct)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic offer_abc(input logic [DATA_WIDTH-1:0] a, b, c);
        ldtv_in_t it;
        it.coef_a = a;
        it.coef_b = b;
        it.rhs    = c;
        offer(it);
    endtask

    // Stop offering and wait until every expected result has come back.
    // The first edge lets the monitor note the item accepted just before.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    function automatic longint signed_rand(int bits);
        longint m;
        m = $urandom_range((32'd1 << bits) - 1);
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_corner();
        case ($urandom_range(5))
            0: return '0;
            1: return 1;
            2: return S_NEG1;
            3: return S_MIN;
            4: return S_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Mix of item shapes:
    //  - full-width random: every bit toggles, mostly gcd 1
    //  - built from a common factor: solvable with real scaling, sometimes
    //    nudged off so the gcd no longer divides rhs
    //  - tiny values: zeros, units and small gcds show up often
    //  - corner values mixed with random ones
    function automatic ldtv_in_t random_item();
        ldtv_in_t it;
        longint   g, m, n, kk;
        int       kind;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            it.coef_a = $urandom;
            it.coef_b = $urandom;
            it.rhs    = $urandom;
        end
        else if (kind < 70)
        begin
            g  = signed_rand($urandom_range(10, 1));
            if (g == 0)
                g = 1;
            m  = signed_rand($urandom_range(20, 1));
            n  = signed_rand($urandom_range(20, 1));
            kk = signed_rand($urandom_range(20, 1));
            it.coef_a = DATA_WIDTH'(g * m);
            it.coef_b = DATA_WIDTH'(g * n);
            it.rhs    = DATA_WIDTH'(g * kk + (($urandom_range(4) == 0) ? 1 : 0));
        end
        else if (kind < 85)
        begin
            it.coef_a = DATA_WIDTH'($urandom_range(40) - 20);
            it.coef_b = DATA_WIDTH'($urandom_range(40) - 20);
            it.rhs    = DATA_WIDTH'($urandom_range(40) - 20);
        end
        else
        begin
            it.coef_a = pick_corner();
            it.coef_b = pick_corner();
            it.rhs    = pick_corner();
        end
        return it;
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        hold_request = 0;
        cycle_count = 0;
        sender_idle_pct = 28;
        recv_idle_pct = 55;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items
        offer_abc(0, 0, 0);                  // both zero, rhs zero: solvable
        offer_abc(0, 0, 5);                  // both zero, rhs nonzero: no solution
        offer_abc(0, 7, 21);                 // a zero: no Euclid steps
        offer_abc(6, 0, -18);
        offer_abc(4, 6, 3);                  // gcd does not divide rhs
        offer_abc(4, 6, 10);
        offer_abc(-12, 18, -6);              // mixed signs: gcd comes out positive
        offer_abc(12, -18, 7);
        offer_abc(S_MIN, S_MIN, S_MIN);      // most negative everywhere
        offer_abc(S_MAX, S_MAX, S_MAX);
        offer_abc(S_MIN, S_NEG1, S_MAX);     // min / -1 quotient
        offer_abc(S_NEG1, S_MIN, S_MIN);
        offer_abc(S_MAX, S_MIN, 1);
        offer_abc(S_MIN, S_MAX, S_NEG1);
        offer_abc(0, S_MIN, S_MIN);          // gcd is the most negative value
        offer_abc(S_MIN, 0, 0);
        offer_abc(1, 1, 0);
        offer_abc(S_NEG1, S_NEG1, S_MIN);
        // consecutive Fibonacci numbers: the longest Euclid chain
        offer_abc(32'd1836311903, 32'd1134903170, S_MAX);
        offer_abc(-32'sd1836311903, 32'd1134903170, S_MIN);
        offer_abc(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        offer_abc(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);

        // Sender pauses until the block has returned everything.
        drain();

        // Receiver holds off long enough for the block to fill its output
        // register and a second solve, so req_ready stays low meanwhile.
        hold_request = 6000;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 55;
                recv_idle_pct = 28;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            offer(random_item());
        end

        drain();
        repeat (ITEM_CYCLES) @(posedge clk);

        if (board.pending() != 0)
            board.report($sformatf("%0d results never returned", board.pending()));

        if (board.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
